// ----- rtl/core/sre_pkg.sv -----
// Shared types, constants and coefficient tables for the shape raster engine.
`default_nettype none

package sre_pkg;

	localparam int CANVAS_WIDTH_DEF  = 70;
	localparam int CANVAS_HEIGHT_DEF = 40;

	// Q16 fixed point
	localparam logic signed [19:0] Q16_ONE = 20'sd65536;
	localparam logic [18:0] HALF_PI_1 = 19'd102944;
	localparam logic [18:0] HALF_PI_2 = 19'd205888;
	localparam logic [18:0] HALF_PI_3 = 19'd308832;
	localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;

	// Horner steps 0..4 build sine, 5..10 build cosine
	localparam logic [3:0] K_SIN_LAST  = 4'd4;
	localparam logic [3:0] K_COS_FIRST = 4'd5;
	localparam logic [3:0] K_COS_LAST  = 4'd10;

	// exact division by a small constant: q = (a * ceil(2^29 / k)) >> 29 for a < 2^21
	localparam int RECIP_SHIFT = 29;

	typedef enum logic [1:0] {
		CMD_LINE   = 2'd0,
		CMD_RECT   = 2'd1,
		CMD_CIRCLE = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_WAIT,
		ST_RD_DONE,
		ST_L_SETUP,
		ST_L_PLOT,
		ST_C_INIT,
		ST_C_DIV,
		ST_C_CHECK,
		ST_C_SQ,
		ST_C_U2,
		ST_H_MUL,
		ST_H_REC,
		ST_H_UPD,
		ST_S_MUL,
		ST_S_SET,
		ST_X_MUL,
		ST_X_SET,
		ST_Y_MUL,
		ST_Y_SET,
		ST_C_PLOT
	} state_t;

	// reciprocal of the Horner divisor of step k
	function automatic logic [28:0] recip(input logic [3:0] k);
		case (k)
			4'd0:    recip = 29'd4880645;   // 110
			4'd1:    recip = 29'd7456541;   // 72
			4'd2:    recip = 29'd12782641;  // 42
			4'd3:    recip = 29'd26843546;  // 20
			4'd4:    recip = 29'd89478486;  // 6
			4'd5:    recip = 29'd4067204;   // 132
			4'd6:    recip = 29'd5965233;   // 90
			4'd7:    recip = 29'd9586981;   // 56
			4'd8:    recip = 29'd17895698;  // 30
			4'd9:    recip = 29'd44739243;  // 12
			4'd10:   recip = 29'd268435456; // 2
			default: recip = 29'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/shape_raster_engine_top.sv -----
// Top level of the shape raster engine: command sequencer, shared multiplier, canvas RAM.
`default_nettype none

// One-bit canvas of CANVAS_WIDTH x CANVAS_HEIGHT pixels, blank after reset, driven by
// one command per request (line, rectangle, circle, pixel read). A request is taken on
// a clock edge with start high and busy low; busy stays high until the command is done.
// Every request gives exactly one result: done pulses for one cycle with done_command
// (echo of the command) and pixel_value (the pixel for a read, 0 otherwise). The result
// cannot be held off by the receiver. After reset the canvas RAM is swept to zero, one
// pixel per cycle, and busy stays high until all CANVAS_WIDTH*CANVAS_HEIGHT pixels (2800 at
// the default size) are cleared; only then is the first request taken.
// Work from request to done:
//   read:       RAM read is registered.
//   line:       num + 1 points, num = max(|dx|, |dy|), one point per cycle.
//   rectangle:  its four sides, each set up and drawn in turn as a line.
//   circle:     ceil(2*pi*r) - 1 points; each point runs the
//               sine/cosine Horner series through the one 30x30 multiplier,
//               each term passing through the states H_MUL, H_REC and H_UPD.
//   circle with r <= 0: nothing is drawn.
// Points off the canvas are skipped; lines round half up, circle points are truncated
// toward zero from Q16 fixed point.

module shape_raster_engine_top #(
	parameter int CANVAS_WIDTH  = sre_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = sre_pkg::CANVAS_HEIGHT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	input  wire logic [1:0]        command,
	input  wire logic signed [8:0] x_start,
	input  wire logic signed [8:0] y_start,
	input  wire logic signed [8:0] x_end,
	input  wire logic signed [8:0] y_end,
	output logic                   pixel_value,
	output logic [1:0]             done_command
);

	localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic signed [10:0] W_S = 11'(CANVAS_WIDTH);
	localparam logic signed [10:0] H_S = 11'(CANVAS_HEIGHT);
	localparam int RS = sre_pkg::RECIP_SHIFT;

	function automatic logic in_canvas(input logic signed [10:0] x,
		input logic signed [10:0] y);
		in_canvas = (x >= 11'sd0) && (x < W_S) && (y >= 11'sd0) && (y < H_S);
	endfunction

	function automatic logic [AW-1:0] pix_addr(input logic [7:0] x, input logic [7:0] y);
		logic [16:0] full;
		full = 17'(y) * 17'(CANVAS_WIDTH) + 17'(x);
		pix_addr = full[AW-1:0];
	endfunction

	// ---------------- state ----------------
	sre_pkg::state_t state_q, state_d;
	logic            done_q;
	logic [AW-1:0]   clr_q;

	// latched request
	sre_pkg::cmd_t   cmd_q;
	logic signed [8:0] xs_q, ys_q, xe_q, ye_q;
	logic            pix_q;
	logic            rd_on_q;
	logic [AW-1:0]   rd_addr_q;

	// line DDA
	logic [1:0]        seg_q;
	logic signed [9:0] dx_q, dy_q;
	logic [8:0]        num_q, li_q;
	logic signed [11:0] remx_q, remy_q;
	logic signed [10:0] pt_x_q, pt_y_q;

	// circle
	logic [10:0] n_q, ci_q;
	logic [7:0]  dv_rem_q;
	logic [16:0] dv_quo_q;
	logic [4:0]  dv_cnt_q;
	logic [18:0] theta_q;
	logic [8:0]  trem_q;
	logic [16:0] q0_q;
	logic [7:0]  r0_q;
	logic [1:0]  quad_q;
	logic [16:0] u_q;
	logic [17:0] u2_q;
	logic signed [19:0] t_q, s_q, c_q;
	logic [3:0]  k_q;
	logic        neg_q;
	logic signed [59:0] prod_q;

	// ---------------- canvas RAM ----------------
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic          ram_rdata;

	sre_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_canvas (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	// ---------------- request decode ----------------
	logic signed [10:0] in_x11, in_y11;
	assign in_x11 = {{2{x_start[8]}}, x_start};
	assign in_y11 = {{2{y_start[8]}}, y_start};

	// ---------------- line edge setup ----------------
	logic signed [8:0] lx0, ly0, lx1, ly1;
	logic signed [9:0] ldx, ldy, adx, ady;
	logic [8:0]        lnum;

	always_comb begin
		case (seg_q)
			2'd0: begin
				lx0 = xs_q; ly0 = ys_q;
				lx1 = (cmd_q == sre_pkg::CMD_RECT) ? xs_q : xe_q;
				ly1 = ye_q;
			end
			2'd1: begin lx0 = xs_q; ly0 = ye_q; lx1 = xe_q; ly1 = ye_q; end
			2'd2: begin lx0 = xe_q; ly0 = ye_q; lx1 = xe_q; ly1 = ys_q; end
			default: begin lx0 = xe_q; ly0 = ys_q; lx1 = xs_q; ly1 = ys_q; end
		endcase
		ldx  = {lx1[8], lx1} - {lx0[8], lx0};
		ldy  = {ly1[8], ly1} - {ly0[8], ly0};
		adx  = ldx[9] ? -ldx : ldx;
		ady  = ldy[9] ? -ldy : ldy;
		lnum = (adx >= ady) ? adx[8:0] : ady[8:0];
	end

	// ---------------- line DDA step ----------------
	// numerator 2*i*d + num kept as quotient (the coordinate) plus remainder in [0, 2num)
	logic signed [11:0] two_num, rx_sum, ry_sum, rx_n, ry_n;
	logic signed [10:0] px_n, py_n;
	logic               line_end, line_last;

	always_comb begin
		two_num = {2'b00, num_q, 1'b0};
		rx_sum  = remx_q + {dx_q[9], dx_q, 1'b0};
		ry_sum  = remy_q + {dy_q[9], dy_q, 1'b0};
		rx_n = rx_sum;
		px_n = pt_x_q;
		if (rx_sum >= two_num) begin
			rx_n = rx_sum - two_num;
			px_n = pt_x_q + 11'sd1;
		end else if (rx_sum < 12'sd0) begin
			rx_n = rx_sum + two_num;
			px_n = pt_x_q - 11'sd1;
		end
		ry_n = ry_sum;
		py_n = pt_y_q;
		if (ry_sum >= two_num) begin
			ry_n = ry_sum - two_num;
			py_n = pt_y_q + 11'sd1;
		end else if (ry_sum < 12'sd0) begin
			ry_n = ry_sum + two_num;
			py_n = pt_y_q - 11'sd1;
		end
		line_end  = (li_q == num_q);
		line_last = line_end && ((cmd_q == sre_pkg::CMD_LINE) || (seg_q == 2'd3));
	end

	// ---------------- circle setup and stepping ----------------
	logic [7:0]  r8;
	logic        r_pos;
	logic [42:0] n_full;
	logic [10:0] n_calc;
	logic [8:0]  dv_sh;
	logic [7:0]  dv_rem_n;
	logic [16:0] dv_quo_n;
	logic [8:0]  trem_sum, trem_n;
	logic        trem_carry;
	logic [18:0] theta_n;
	logic [1:0]  quad_c;
	logic [18:0] u_full;

	always_comb begin
		r8     = xe_q[7:0];
		r_pos  = !xe_q[8] && (xe_q != 9'sd0);
		// index bound n = ceil(2*pi*r) as r * 2pi in Q32; points 1 to n-1 are drawn
		n_full = 43'(r8) * 43'(sre_pkg::TWO_PI_Q32);
		n_calc = n_full[42:32] + 11'd1;

		// restoring divide of 2^16 by r, one quotient bit a cycle
		dv_sh = {dv_rem_q, (dv_cnt_q == 5'd16)};
		if (dv_sh >= {1'b0, r8}) begin
			dv_rem_n = 8'(dv_sh - {1'b0, r8});
			dv_quo_n = {dv_quo_q[15:0], 1'b1};
		end else begin
			dv_rem_n = dv_sh[7:0];
			dv_quo_n = {dv_quo_q[15:0], 1'b0};
		end

		// theta = floor(i * 2^16 / r), stepped by quotient and remainder of 2^16 / r
		trem_sum   = trem_q + {1'b0, r0_q};
		trem_carry = (trem_sum >= {1'b0, r8});
		trem_n     = trem_carry ? (trem_sum - {1'b0, r8}) : trem_sum;
		theta_n    = theta_q + {2'b00, q0_q} + {18'd0, trem_carry};

		// quadrant reduction
		if (theta_q >= sre_pkg::HALF_PI_3) begin
			quad_c = 2'd3; u_full = theta_q - sre_pkg::HALF_PI_3;
		end else if (theta_q >= sre_pkg::HALF_PI_2) begin
			quad_c = 2'd2; u_full = theta_q - sre_pkg::HALF_PI_2;
		end else if (theta_q >= sre_pkg::HALF_PI_1) begin
			quad_c = 2'd1; u_full = theta_q - sre_pkg::HALF_PI_1;
		end else begin
			quad_c = 2'd0; u_full = theta_q;
		end
	end

	// ---------------- shared multiplier ----------------
	logic signed [29:0] mul_a, mul_b;
	logic signed [59:0] mul_p;
	logic signed [59:0] prod_abs;
	logic [20:0]        hmag;
	logic signed [19:0] hq, t_new;
	logic signed [19:0] cos_m, sin_m;

	always_comb begin
		prod_abs = prod_q[59] ? -prod_q : prod_q;
		hmag     = prod_abs[36:16];
		hq       = {1'b0, prod_q[RS+18:RS]};
		t_new    = sre_pkg::Q16_ONE - (neg_q ? -hq : hq);
		case (quad_q)
			2'd0: begin cos_m = c_q;  sin_m = s_q;  end
			2'd1: begin cos_m = -s_q; sin_m = c_q;  end
			2'd2: begin cos_m = -c_q; sin_m = -s_q; end
			default: begin cos_m = s_q; sin_m = -c_q; end
		endcase

		mul_a = '0;
		mul_b = '0;
		case (state_q)
			sre_pkg::ST_C_SQ: begin
				mul_a = {13'd0, u_q};
				mul_b = {13'd0, u_q};
			end
			sre_pkg::ST_H_MUL: begin
				mul_a = {12'd0, u2_q};
				mul_b = {{10{t_q[19]}}, t_q};
			end
			sre_pkg::ST_H_REC: begin
				mul_a = {9'd0, hmag};
				mul_b = {1'b0, sre_pkg::recip(k_q)};
			end
			sre_pkg::ST_S_MUL: begin
				mul_a = {13'd0, u_q};
				mul_b = {{10{t_q[19]}}, t_q};
			end
			sre_pkg::ST_X_MUL: begin
				mul_a = {22'd0, r8};
				mul_b = {{10{cos_m[19]}}, cos_m};
			end
			sre_pkg::ST_Y_MUL: begin
				mul_a = {22'd0, r8};
				mul_b = {{10{sin_m[19]}}, sin_m};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// divide by 2^16 truncating toward zero, optionally after adding a centre
	logic signed [59:0] tr_in, tr_out, cen;

	always_comb begin
		cen = '0;
		if (state_q == sre_pkg::ST_X_SET) begin
			cen = {{35{xs_q[8]}}, xs_q, 16'd0};
		end else if (state_q == sre_pkg::ST_Y_SET) begin
			cen = {{35{ys_q[8]}}, ys_q, 16'd0};
		end
		tr_in  = cen + prod_q;
		tr_out = tr_in + (tr_in[59] ? 60'sd65535 : 60'sd0);
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sre_pkg::ST_CLEAR:   if (clr_q == LAST_ADDR) state_d = sre_pkg::ST_IDLE;
			sre_pkg::ST_IDLE: begin
				if (start) begin
					unique case (sre_pkg::cmd_t'(command)) inside
						sre_pkg::CMD_LINE, sre_pkg::CMD_RECT: state_d = sre_pkg::ST_L_SETUP;
						sre_pkg::CMD_CIRCLE: state_d = sre_pkg::ST_C_INIT;
						default:             state_d = sre_pkg::ST_RD_WAIT;
					endcase
				end
			end
			sre_pkg::ST_RD_WAIT: state_d = sre_pkg::ST_RD_DONE;
			sre_pkg::ST_RD_DONE: state_d = sre_pkg::ST_IDLE;
			sre_pkg::ST_L_SETUP: state_d = sre_pkg::ST_L_PLOT;
			sre_pkg::ST_L_PLOT: begin
				if (line_last) begin
					state_d = sre_pkg::ST_IDLE;
				end else if (line_end) begin
					state_d = sre_pkg::ST_L_SETUP;
				end
			end
			sre_pkg::ST_C_INIT:  state_d = r_pos ? sre_pkg::ST_C_DIV : sre_pkg::ST_IDLE;
			sre_pkg::ST_C_DIV:   if (dv_cnt_q == 5'd0) state_d = sre_pkg::ST_C_CHECK;
			sre_pkg::ST_C_CHECK: state_d = (ci_q >= n_q) ? sre_pkg::ST_IDLE : sre_pkg::ST_C_SQ;
			sre_pkg::ST_C_SQ:    state_d = sre_pkg::ST_C_U2;
			sre_pkg::ST_C_U2:    state_d = sre_pkg::ST_H_MUL;
			sre_pkg::ST_H_MUL:   state_d = sre_pkg::ST_H_REC;
			sre_pkg::ST_H_REC:   state_d = sre_pkg::ST_H_UPD;
			sre_pkg::ST_H_UPD: begin
				if (k_q == sre_pkg::K_SIN_LAST) begin
					state_d = sre_pkg::ST_S_MUL;
				end else if (k_q == sre_pkg::K_COS_LAST) begin
					state_d = sre_pkg::ST_X_MUL;
				end else begin
					state_d = sre_pkg::ST_H_MUL;
				end
			end
			sre_pkg::ST_S_MUL:   state_d = sre_pkg::ST_S_SET;
			sre_pkg::ST_S_SET:   state_d = sre_pkg::ST_H_MUL;
			sre_pkg::ST_X_MUL:   state_d = sre_pkg::ST_X_SET;
			sre_pkg::ST_X_SET:   state_d = sre_pkg::ST_Y_MUL;
			sre_pkg::ST_Y_MUL:   state_d = sre_pkg::ST_Y_SET;
			sre_pkg::ST_Y_SET:   state_d = sre_pkg::ST_C_PLOT;
			sre_pkg::ST_C_PLOT:  state_d = sre_pkg::ST_C_CHECK;
			default:             state_d = sre_pkg::ST_IDLE;
		endcase
	end

	// ---------------- outputs of the sequencer ----------------
	logic finish, fin_pix;
	logic plotting;

	always_comb begin
		busy      = (state_q != sre_pkg::ST_IDLE);
		plotting  = (state_q == sre_pkg::ST_L_PLOT) || (state_q == sre_pkg::ST_C_PLOT);
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 1'b0;
		if (state_q == sre_pkg::ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (plotting) begin
			ram_we    = in_canvas(pt_x_q, pt_y_q);
			ram_waddr = pix_addr(pt_x_q[7:0], pt_y_q[7:0]);
			ram_wdata = 1'b1;
		end

		finish  = 1'b0;
		fin_pix = 1'b0;
		unique case (state_q)
			sre_pkg::ST_RD_DONE: begin
				finish  = 1'b1;
				fin_pix = rd_on_q & ram_rdata;
			end
			sre_pkg::ST_L_PLOT:  finish = line_last;
			sre_pkg::ST_C_INIT:  finish = !r_pos;
			sre_pkg::ST_C_CHECK: finish = (ci_q >= n_q);
			default:             finish = 1'b0;
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sre_pkg::ST_CLEAR;
			done_q  <= 1'b0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (state_q == sre_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (finish) begin
			pix_q <= fin_pix;
		end
		unique case (state_q)
			sre_pkg::ST_IDLE: begin
				if (start) begin
					cmd_q     <= sre_pkg::cmd_t'(command);
					xs_q      <= x_start;
					ys_q      <= y_start;
					xe_q      <= x_end;
					ye_q      <= y_end;
					seg_q     <= 2'd0;
					rd_on_q   <= in_canvas(in_x11, in_y11);
					rd_addr_q <= pix_addr(x_start[7:0], y_start[7:0]);
				end
			end
			sre_pkg::ST_L_SETUP: begin
				dx_q   <= ldx;
				dy_q   <= ldy;
				num_q  <= lnum;
				li_q   <= 9'd0;
				pt_x_q <= {{2{lx0[8]}}, lx0};
				pt_y_q <= {{2{ly0[8]}}, ly0};
				remx_q <= {3'b000, lnum};
				remy_q <= {3'b000, lnum};
			end
			sre_pkg::ST_L_PLOT: begin
				if (!line_end) begin
					li_q   <= li_q + 9'd1;
					pt_x_q <= px_n;
					pt_y_q <= py_n;
					remx_q <= rx_n;
					remy_q <= ry_n;
				end else if (!line_last) begin
					seg_q <= seg_q + 2'd1;
				end
			end
			sre_pkg::ST_C_INIT: begin
				n_q      <= n_calc;
				dv_rem_q <= 8'd0;
				dv_quo_q <= 17'd0;
				dv_cnt_q <= 5'd16;
			end
			sre_pkg::ST_C_DIV: begin
				dv_rem_q <= dv_rem_n;
				dv_quo_q <= dv_quo_n;
				dv_cnt_q <= dv_cnt_q - 5'd1;
				if (dv_cnt_q == 5'd0) begin
					theta_q <= {2'b00, dv_quo_n};
					trem_q  <= {1'b0, dv_rem_n};
					q0_q    <= dv_quo_n;
					r0_q    <= dv_rem_n;
					ci_q    <= 11'd1;
				end
			end
			sre_pkg::ST_C_CHECK: begin
				quad_q <= quad_c;
				u_q    <= u_full[16:0];
			end
			sre_pkg::ST_C_U2: begin
				u2_q <= prod_q[33:16];
				t_q  <= sre_pkg::Q16_ONE;
				k_q  <= 4'd0;
			end
			sre_pkg::ST_H_REC: neg_q <= prod_q[59];
			sre_pkg::ST_H_UPD: begin
				t_q <= t_new;
				if (k_q == sre_pkg::K_COS_LAST) begin
					c_q <= t_new;
				end else if (k_q != sre_pkg::K_SIN_LAST) begin
					k_q <= k_q + 4'd1;
				end
			end
			sre_pkg::ST_S_SET: begin
				s_q <= tr_out[35:16];
				t_q <= sre_pkg::Q16_ONE;
				k_q <= sre_pkg::K_COS_FIRST;
			end
			sre_pkg::ST_X_SET: pt_x_q <= tr_out[26:16];
			sre_pkg::ST_Y_SET: pt_y_q <= tr_out[26:16];
			sre_pkg::ST_C_PLOT: begin
				ci_q    <= ci_q + 11'd1;
				theta_q <= theta_n;
				trem_q  <= trem_n;
			end
			default: begin
			end
		endcase
	end

	assign done         = done_q;
	assign pixel_value  = pix_q;
	assign done_command = cmd_q;

	// ---------------- assertions ----------------
	// finish is only raised outside idle and done is shown in idle, so results never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for two cycles");

	// a result is only shown once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// drawing commands report a zero pixel
	a_draw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (done_command != sre_pkg::CMD_READ)) |-> !pixel_value)
		else $error("pixel set on a drawing result");

endmodule

`default_nettype wire

// ----- rtl/core/sre_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sre_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
